// File: design/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and codes for the floppy sector controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Bus access kinds carried in the action field
  typedef enum logic [1:0] {
    ACT_DATA_IN  = 2'd0,
    ACT_DATA_OUT = 2'd1,
    ACT_START    = 2'd2,
    ACT_PULSE    = 2'd3
  } action_t;

  // Command operations, bits 9:8 of the command field
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RECAL = 2'd2,
    OP_SEEK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_SECTOR = 2'd1,
    ERR_TRACK  = 2'd2
  } err_t;

  // Work items after classification by the front end
  typedef enum logic [2:0] {
    JOB_DATA_IN,
    JOB_DATA_OUT,
    JOB_PULSE,
    JOB_READ,
    JOB_WRITE,
    JOB_RECAL,
    JOB_SEEK,
    JOB_REJECT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;  // byte for the write buffer
    logic [7:0] arg;   // sector (1-based) or track
    err_t       err;   // error code of a rejected command
  } job_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_BASE,
    ST_COPY
  } back_state_t;

endpackage

// File: design/fsc_if.sv
// ----------------------------------------------------------------------------
// fsc_if
// Valid/ready channels: bus access words in, result words out.
// ----------------------------------------------------------------------------
interface fsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] write_data;
  logic [9:0] command;

  modport source (output valid, action, write_data, command, input ready);
  modport sink   (input valid, action, write_data, command, output ready);
endinterface

interface fsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] error;

  modport source (output valid, read_data, error, input ready);
  modport sink   (input valid, read_data, error, output ready);
endinterface

// File: design/fsc_ram.sv
// ----------------------------------------------------------------------------
// fsc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsc_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/fsc_front.sv
// ----------------------------------------------------------------------------
// fsc_front
// Accepts bus access words and classifies them into jobs, range checks incl.
// ----------------------------------------------------------------------------
module fsc_front #(
  parameter int SECTORS_PER_TRACK = 26,
  parameter int TRACK_COUNT       = 77
) (
  fsc_in_if.sink       in_ch,
  input  logic         clearing,
  output logic         push_valid,
  input  logic         push_ready,
  output fsc_pkg::job_t push_job
);

  localparam logic [7:0] SPT_L   = 8'(SECTORS_PER_TRACK);
  localparam logic [7:0] TRACKS_L = 8'(TRACK_COUNT);

  logic [7:0] arg;
  logic       sector_bad;

  assign arg        = in_ch.command[7:0];
  assign sector_bad = (arg == 8'd0) || (arg > SPT_L);

  // no words taken while the image is being cleared
  assign in_ch.ready = push_ready && !clearing;
  assign push_valid  = in_ch.valid && !clearing;

  always_comb begin
    push_job      = '0;
    push_job.data = in_ch.write_data;
    push_job.arg  = arg;
    push_job.err  = fsc_pkg::ERR_OK;
    push_job.kind = fsc_pkg::JOB_PULSE;
    case (fsc_pkg::action_t'(in_ch.action))
      fsc_pkg::ACT_DATA_IN:  push_job.kind = fsc_pkg::JOB_DATA_IN;
      fsc_pkg::ACT_DATA_OUT: push_job.kind = fsc_pkg::JOB_DATA_OUT;
      fsc_pkg::ACT_START: begin
        case (fsc_pkg::op_t'(in_ch.command[9:8]))
          fsc_pkg::OP_READ, fsc_pkg::OP_WRITE: begin
            if (sector_bad) begin
              push_job.kind = fsc_pkg::JOB_REJECT;
              push_job.err  = fsc_pkg::ERR_SECTOR;
            end else if (fsc_pkg::op_t'(in_ch.command[9:8]) == fsc_pkg::OP_READ) begin
              push_job.kind = fsc_pkg::JOB_READ;
            end else begin
              push_job.kind = fsc_pkg::JOB_WRITE;
            end
          end
          fsc_pkg::OP_RECAL: push_job.kind = fsc_pkg::JOB_RECAL;
          fsc_pkg::OP_SEEK: begin
            if (arg >= TRACKS_L) begin
              push_job.kind = fsc_pkg::JOB_REJECT;
              push_job.err  = fsc_pkg::ERR_TRACK;
            end else begin
              push_job.kind = fsc_pkg::JOB_SEEK;
            end
          end
          default: push_job.kind = fsc_pkg::JOB_RECAL;
        endcase
      end
      default: push_job.kind = fsc_pkg::JOB_PULSE;
    endcase
  end

endmodule

// File: design/fsc_queue.sv
// ----------------------------------------------------------------------------
// fsc_queue
// Two-entry job queue between front end and back end.
// ----------------------------------------------------------------------------
module fsc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  fsc_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fsc_pkg::job_t pop_job
);

  fsc_pkg::job_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/fsc_back.sv
// ----------------------------------------------------------------------------
// fsc_back
// Executes jobs: image and write buffer stores, track/pointer state, result.
// ----------------------------------------------------------------------------
module fsc_back #(
  parameter int BYTES_PER_SECTOR  = 128,
  parameter int SECTORS_PER_TRACK = 26,
  parameter int TRACK_COUNT       = 77
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  fsc_pkg::job_t pop_job,
  fsc_out_if.source     out_ch,
  output logic          clearing
);

  localparam int SEC_TOTAL = TRACK_COUNT * SECTORS_PER_TRACK;
  localparam int IMG_BYTES = SEC_TOTAL * BYTES_PER_SECTOR;
  localparam int IAW       = $clog2(IMG_BYTES);
  localparam int BW        = $clog2(BYTES_PER_SECTOR);
  localparam int WCW       = $clog2(BYTES_PER_SECTOR + 1);
  localparam int TW        = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int PW        = (SEC_TOTAL > 1) ? $clog2(SEC_TOTAL) : 1;

  localparam logic [IAW-1:0] IMG_LAST   = IAW'(IMG_BYTES - 1);
  localparam logic [IAW-1:0] BUF_LAST   = IAW'(BYTES_PER_SECTOR - 1);
  localparam logic [WCW-1:0] BPS_W      = WCW'(BYTES_PER_SECTOR);
  localparam logic [TW-1:0]  TRACK_LAST = TW'(TRACK_COUNT - 1);

  fsc_pkg::back_state_t state_r, state_nxt;
  logic [IAW-1:0] rp_r, rp_nxt;
  logic [TW-1:0]  track_r, track_nxt;
  logic [WCW-1:0] wc_r, wc_nxt;
  logic [IAW-1:0] clr_r, clr_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  fsc_pkg::job_t  job_r, job_nxt;
  logic [WCW-1:0] cp_r, cp_nxt;
  logic [IAW-1:0] wa_r, wa_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r, out_data_nxt;
  fsc_pkg::err_t  out_err_r, out_err_nxt;

  logic           slot_free;
  logic           load;
  logic [IAW-1:0] base;

  logic           img_we;
  logic [IAW-1:0] img_wa, img_ra;
  logic [7:0]     img_wd, img_rd;
  logic           buf_we;
  logic [BW-1:0]  buf_wa, buf_ra;
  logic [7:0]     buf_wd, buf_rd;

  fsc_ram #(.WIDTH(8), .DEPTH(IMG_BYTES)) u_image (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_wa),
    .wdata (img_wd),
    .raddr (img_ra),
    .rdata (img_rd)
  );

  fsc_ram #(.WIDTH(8), .DEPTH(BYTES_PER_SECTOR)) u_wbuf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_wa),
    .wdata (buf_wd),
    .raddr (buf_ra),
    .rdata (buf_rd)
  );

  assign clearing  = (state_r == fsc_pkg::ST_CLEAR);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign base      = IAW'(prod_r) * IAW'(BYTES_PER_SECTOR);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.error     = out_err_r;

  always_comb begin
    state_nxt    = state_r;
    rp_nxt       = rp_r;
    track_nxt    = track_r;
    wc_nxt       = wc_r;
    clr_nxt      = clr_r;
    prod_nxt     = prod_r;
    job_nxt      = job_r;
    cp_nxt       = cp_r;
    wa_nxt       = wa_r;
    pop_ready    = 1'b0;
    load         = 1'b0;
    out_data_nxt = out_data_r;
    out_err_nxt  = out_err_r;
    img_we       = 1'b0;
    img_wa       = wa_r;
    img_wd       = buf_rd;
    img_ra       = rp_r;
    buf_we       = 1'b0;
    buf_wa       = wc_r[BW-1:0];
    buf_wd       = pop_job.data;
    buf_ra       = '0;

    case (state_r)
      fsc_pkg::ST_CLEAR: begin
        img_we = 1'b1;
        img_wa = clr_r;
        img_wd = 8'd0;
        buf_we = (clr_r <= BUF_LAST);
        buf_wa = clr_r[BW-1:0];
        buf_wd = 8'd0;
        if (clr_r == IMG_LAST) begin
          state_nxt = fsc_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      fsc_pkg::ST_IDLE: begin
        if (pop_valid && slot_free) begin
          pop_ready    = 1'b1;
          job_nxt      = pop_job;
          out_data_nxt = 8'd0;
          out_err_nxt  = fsc_pkg::ERR_OK;
          case (pop_job.kind)
            fsc_pkg::JOB_DATA_IN: begin
              rp_nxt    = (rp_r == IMG_LAST) ? '0 : rp_r + 1'b1;
              state_nxt = fsc_pkg::ST_RD_WAIT;
            end
            fsc_pkg::JOB_DATA_OUT: begin
              if (wc_r != BPS_W) begin
                buf_we = 1'b1;
                wc_nxt = wc_r + 1'b1;
              end
              load = 1'b1;
            end
            fsc_pkg::JOB_PULSE: begin
              wc_nxt = '0;
              load   = 1'b1;
            end
            fsc_pkg::JOB_RECAL: begin
              track_nxt = '0;
              load      = 1'b1;
            end
            fsc_pkg::JOB_SEEK: begin
              track_nxt = pop_job.arg[TW-1:0];
              load      = 1'b1;
            end
            fsc_pkg::JOB_READ, fsc_pkg::JOB_WRITE: begin
              prod_nxt  = PW'(track_r) * PW'(SECTORS_PER_TRACK) + PW'(pop_job.arg - 8'd1);
              state_nxt = fsc_pkg::ST_BASE;
            end
            fsc_pkg::JOB_REJECT: begin
              out_err_nxt = pop_job.err;
              load        = 1'b1;
            end
            default: load = 1'b1;
          endcase
        end
      end

      fsc_pkg::ST_RD_WAIT: begin
        out_data_nxt = img_rd;
        load         = 1'b1;
        state_nxt    = fsc_pkg::ST_IDLE;
      end

      fsc_pkg::ST_BASE: begin
        rp_nxt = base;
        wa_nxt = base;
        wc_nxt = '0;
        if (job_r.kind == fsc_pkg::JOB_WRITE) begin
          cp_nxt    = '0;
          state_nxt = fsc_pkg::ST_COPY;
        end else begin
          load      = 1'b1;
          state_nxt = fsc_pkg::ST_IDLE;
        end
      end

      fsc_pkg::ST_COPY: begin
        // buffer read runs one step ahead of the image write
        if (cp_r != BPS_W) begin
          buf_ra = cp_r[BW-1:0];
        end
        if (cp_r != '0) begin
          img_we = 1'b1;
          wa_nxt = wa_r + 1'b1;
        end
        if (cp_r == BPS_W) begin
          load      = 1'b1;
          state_nxt = fsc_pkg::ST_IDLE;
        end else begin
          cp_nxt = cp_r + 1'b1;
        end
      end

      default: state_nxt = fsc_pkg::ST_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsc_pkg::ST_CLEAR;
      rp_r        <= '0;
      track_r     <= '0;
      wc_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      track_r     <= track_nxt;
      wc_r        <= wc_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    job_r      <= job_nxt;
    cp_r       <= cp_nxt;
    wa_r       <= wa_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    track_r <= TRACK_LAST)
    else $error("current track beyond last track");

  a_wcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= BPS_W)
    else $error("write count beyond sector size");

  a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= IMG_LAST)
    else $error("read pointer beyond image end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_valid_r) |-> out_ch.ready)
    else $error("pending result word overwritten");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop_ready)
    else $error("job taken during clearing pass");

endmodule

// File: design/floppy_sector_controller_unit.sv
// ----------------------------------------------------------------------------
// floppy_sector_controller_unit
// Timing: the result word is registered. Data-out, pulse, seek, recalibrate
//   and rejected commands load it from idle; data-in passes RD_WAIT, read
//   passes BASE, write passes BASE and then copies the sector, one byte/cycle.
// Rate: one short access/cycle while results are taken; busy on data-in/read/write.
// Reset: synchronous, active low; then a clearing pass over all TRACK_COUNT *
//   SECTORS_PER_TRACK * BYTES_PER_SECTOR bytes (256256 by default), in_ch.ready low.
// ----------------------------------------------------------------------------
//
// Structure
//   fsc_front : takes access words, classifies them into jobs and range-checks
//               sector and track numbers (stateless).
//   fsc_queue : two-entry job queue, so the front keeps taking words while the
//               back end is busy copying or a result word waits.
//   fsc_back  : owns all state - disk image RAM, write buffer RAM, current
//               track, read pointer and write count - and the result register.
//
// Notes
//   The image and write buffer are cleared by a sweep after reset; the buffer
//   shares the first sector's worth of that sweep.
//   Sector base address is formed in two registered steps:
//   track * sectors + (sector - 1), then times bytes per sector.
//   A write command copies the whole buffer, stale bytes included.
//   Data-out words past a full buffer are dropped; a pulse only resets the
//   write count.
// ----------------------------------------------------------------------------
module floppy_sector_controller_unit #(
  parameter int BYTES_PER_SECTOR  = 128,
  parameter int SECTORS_PER_TRACK = 26,
  parameter int TRACK_COUNT       = 77
) (
  input  logic       clk,
  input  logic       rst_n,
  fsc_in_if.sink     in_ch,
  fsc_out_if.source  out_ch
);

  logic          clearing;
  logic          push_valid, push_ready;
  fsc_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  fsc_pkg::job_t pop_job;

  // classification of incoming words
  fsc_front #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .TRACK_COUNT       (TRACK_COUNT)
  ) u_front (
    .in_ch      (in_ch),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // decoupling queue
  fsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // execution and result word register
  fsc_back #(
    .BYTES_PER_SECTOR  (BYTES_PER_SECTOR),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .TRACK_COUNT       (TRACK_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch),
    .clearing  (clearing)
  );

endmodule

// File: bench/floppy_sector_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_sector_controller_unit_tb
// Drives bus access words into the floppy sector controller with random
// gaps and result stalls. A behavioural copy of the disk image, write buffer,
// track and pointers predicts every result word, and each one is checked
// in order.
// ----------------------------------------------------------------------------
module floppy_sector_controller_unit_tb;

  localparam int BYTES_PER_SECTOR  = 128;
  localparam int SECTORS_PER_TRACK = 26;
  localparam int TRACK_COUNT       = 77;
  localparam int IMAGE_BYTES       = TRACK_COUNT * SECTORS_PER_TRACK * BYTES_PER_SECTOR;
  localparam int RANDOM_ACCESSES   = 1600;

  typedef struct {
    fsc_pkg::action_t action;
    logic [7:0]       write_data;
    logic [9:0]       command;
    bit               hold;        // wait for every result word before sending
  } access_t;

  typedef struct {
    logic [7:0]    read_data;
    fsc_pkg::err_t error;
  } response_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fsc_in_if  in_bus ();
  fsc_out_if out_bus ();

  floppy_sector_controller_unit #(
    .BYTES_PER_SECTOR (BYTES_PER_SECTOR),
    .SECTORS_PER_TRACK(SECTORS_PER_TRACK),
    .TRACK_COUNT      (TRACK_COUNT)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the controller state. bit arrays start at zero, which
  // matches the cleared image and buffer after reset.
  // --------------------------------------------------------------------------
  bit [7:0]    image_copy [IMAGE_BYTES];
  bit [7:0]    buffer_copy [BYTES_PER_SECTOR];
  int unsigned track_copy;
  int unsigned pointer_copy;
  int unsigned fill_copy;

  access_t   access_queue [$];       // words still to be sent
  response_t expected_responses [$]; // result words owed by the block
  int        accesses_queued;
  int        mismatch_count;
  int        results_seen;
  bit        hold_next;

  // handshake flags, set at the rising edge, read at the falling edge
  bit in_fire;
  bit out_fire;

  // Works out the result word of one access and updates the shadow state
  function automatic response_t controller_response(access_t acc);
    response_t    resp;
    fsc_pkg::op_t op;
    int unsigned  arg;
    int unsigned  base;
    resp.read_data = 8'h00;
    resp.error     = fsc_pkg::ERR_OK;
    case (acc.action)
      fsc_pkg::ACT_DATA_IN: begin
        if (pointer_copy >= IMAGE_BYTES) pointer_copy = 0;
        resp.read_data = image_copy[pointer_copy];
        pointer_copy++;
        // wrap back to the first byte after the image end
        if (pointer_copy >= IMAGE_BYTES) pointer_copy = 0;
      end
      fsc_pkg::ACT_DATA_OUT: begin
        // a full buffer drops further bytes
        if (fill_copy < BYTES_PER_SECTOR) begin
          buffer_copy[fill_copy] = acc.write_data;
          fill_copy++;
        end
      end
      fsc_pkg::ACT_START: begin
        op  = fsc_pkg::op_t'(acc.command[9:8]);
        arg = acc.command[7:0];
        case (op)
          fsc_pkg::OP_READ, fsc_pkg::OP_WRITE: begin
            if (arg < 1 || arg > SECTORS_PER_TRACK) begin
              resp.error = fsc_pkg::ERR_SECTOR;
            end else begin
              base = (track_copy * SECTORS_PER_TRACK + arg - 1) * BYTES_PER_SECTOR;
              if (base > IMAGE_BYTES - BYTES_PER_SECTOR) begin
                resp.error = fsc_pkg::ERR_TRACK;
              end else begin
                pointer_copy = base;
                // whole buffer goes out, stale bytes included
                if (op == fsc_pkg::OP_WRITE) begin
                  for (int i = 0; i < BYTES_PER_SECTOR; i++)
                    image_copy[base + i] = buffer_copy[i];
                end
                fill_copy = 0;
              end
            end
          end
          fsc_pkg::OP_RECAL: track_copy = 0;
          default: begin
            if (arg >= TRACK_COUNT) resp.error = fsc_pkg::ERR_TRACK;
            else track_copy = arg;
          end
        endcase
      end
      default: fill_copy = 0;  // pulse keeps the buffer bytes
    endcase
    return resp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Idle length for one word: mostly a uniform random draw, with quiet stretches of none
  function automatic int idle_cycles(inout int quiet_run);
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_run = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [9:0] command_word(fsc_pkg::op_t op, int arg);
    return {op, arg[7:0]};
  endfunction

  // Fields the access does not use get random values
  task automatic queue_access(fsc_pkg::action_t act, logic [7:0] data, logic [9:0] cmd);
    access_t acc;
    acc.action     = act;
    acc.write_data = (act == fsc_pkg::ACT_DATA_OUT) ? data : 8'($urandom_range(0, 255));
    acc.command    = (act == fsc_pkg::ACT_START) ? cmd : 10'($urandom_range(0, 1023));
    acc.hold       = hold_next;
    hold_next      = 1'b0;
    access_queue.push_back(acc);
    accesses_queued++;
  endtask

  task automatic queue_reads(int count);
    for (int i = 0; i < count; i++) queue_access(fsc_pkg::ACT_DATA_IN, 8'h00, 10'h000);
  endtask

  task automatic queue_fill(int count);
    for (int i = 0; i < count; i++)
      queue_access(fsc_pkg::ACT_DATA_OUT, 8'($urandom_range(0, 255)), 10'h000);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the head of access_queue, holds it until taken, then
  // idles for a drawn number of cycles. Inputs change on the falling edge.
  // --------------------------------------------------------------------------
  int send_gap;
  int send_quiet;

  always @(negedge clk) begin : access_driver
    bit drive_valid;
    drive_valid = in_bus.valid;
    if (rst_n) begin
      if (in_bus.valid && in_fire) begin
        access_queue.delete(0);
        drive_valid = 1'b0;
        send_gap    = idle_cycles(send_quiet);
      end
      if (!drive_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (access_queue.size() != 0 &&
                     !(access_queue[0].hold && expected_responses.size() != 0)) begin
          in_bus.action     <= access_queue[0].action;
          in_bus.write_data <= access_queue[0].write_data;
          in_bus.command    <= access_queue[0].command;
          drive_valid = 1'b1;
        end
      end
      in_bus.valid <= drive_valid;
    end
  end

  // Result side: ready drops for a drawn stall after each word taken
  int sink_stall;
  int sink_quiet;

  always @(negedge clk) begin : result_sink
    if (rst_n) begin
      if (out_fire) sink_stall = idle_cycles(sink_quiet);
      if (sink_stall > 0) begin
        sink_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, checks a result word against the oldest
  // prediction, then predicts for any access word taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : bus_monitor
    response_t want;
    access_t   seen;
    in_fire  <= rst_n && in_bus.valid && in_bus.ready;
    out_fire <= rst_n && out_bus.valid && out_bus.ready;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("result word %0d with none expected", results_seen));
      end else begin
        want = expected_responses.pop_front();
        if (out_bus.read_data !== want.read_data)
          report_mismatch($sformatf("result word %0d read_data %h, expected %h",
                                    results_seen, out_bus.read_data, want.read_data));
        if (out_bus.error !== want.error)
          report_mismatch($sformatf("result word %0d error %h, expected %h",
                                    results_seen, out_bus.error, want.error));
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      seen.action     = fsc_pkg::action_t'(in_bus.action);
      seen.write_data = in_bus.write_data;
      seen.command    = in_bus.command;
      seen.hold       = 1'b0;
      expected_responses.push_back(controller_response(seen));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int trk;
    int sec;
    int pick;
    int last_trk;
    int last_sec;

    in_bus.valid      = 1'b0;
    in_bus.action     = fsc_pkg::ACT_DATA_IN;
    in_bus.write_data = 8'h00;
    in_bus.command    = 10'h000;
    out_bus.ready     = 1'b0;
    last_trk          = 0;
    last_sec          = 1;

    // -- directed --
    queue_access(fsc_pkg::ACT_DATA_IN, 8'h00, 10'h000);      // fresh image reads zero
    queue_access(fsc_pkg::ACT_PULSE, 8'h00, 10'h000);
    queue_access(fsc_pkg::ACT_DATA_OUT, 8'h00, 10'h000);
    queue_access(fsc_pkg::ACT_DATA_OUT, 8'hff, 10'h000);
    queue_access(fsc_pkg::ACT_DATA_OUT, 8'ha5, 10'h000);
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_WRITE, 1));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, 1));
    queue_reads(3);
    // sector numbers outside 1..26 answer a sector error
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, 0));
    queue_access(fsc_pkg::ACT_START, 8'h00,
                 command_word(fsc_pkg::OP_WRITE, SECTORS_PER_TRACK + 1));
    queue_access(fsc_pkg::ACT_START, 8'h00,
                 command_word(fsc_pkg::OP_READ, SECTORS_PER_TRACK));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, 255));
    // last track, one past it, and the widest track number
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, TRACK_COUNT - 1));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, TRACK_COUNT));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, 255));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_RECAL, 255));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, 0));
    // partly filled buffer: the sector gets the old bytes behind the new one
    queue_access(fsc_pkg::ACT_PULSE, 8'h00, 10'h000);
    queue_access(fsc_pkg::ACT_DATA_OUT, 8'h3c, 10'h000);
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_WRITE, 2));
    hold_next = 1'b1;
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, 2));
    queue_reads(2);

    // -- random, long special cases first --
    // full buffer: bytes beyond one sector are dropped
    queue_access(fsc_pkg::ACT_PULSE, 8'h00, 10'h000);
    queue_fill($urandom_range(129, 134));
    trk = $urandom_range(0, 2);
    sec = $urandom_range(1, SECTORS_PER_TRACK);
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, trk));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_WRITE, sec));
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, sec));
    queue_reads($urandom_range(4, 12));
    last_trk = trk;
    last_sec = sec;

    // pointer wrap: last sector of the last track, read on into sector one
    queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, TRACK_COUNT - 1));
    queue_access(fsc_pkg::ACT_PULSE, 8'h00, 10'h000);
    queue_fill(8);
    queue_access(fsc_pkg::ACT_START, 8'h00,
                 command_word(fsc_pkg::OP_WRITE, SECTORS_PER_TRACK));
    queue_access(fsc_pkg::ACT_START, 8'h00,
                 command_word(fsc_pkg::OP_READ, SECTORS_PER_TRACK));
    queue_reads(BYTES_PER_SECTOR + $urandom_range(1, 8));

    while (accesses_queued < RANDOM_ACCESSES + 25) begin
      pick      = $urandom_range(0, 99);
      hold_next = ($urandom_range(0, 49) == 0);
      // a few tracks and sectors take most traffic, so reads find written data
      trk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TRACK_COUNT - 1)
                                        : $urandom_range(0, 2);
      sec = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                 : $urandom_range(1, SECTORS_PER_TRACK);
      if (pick < 40) begin
        // sector write, often read back
        queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, trk));
        if ($urandom_range(0, 1)) queue_access(fsc_pkg::ACT_PULSE, 8'h00, 10'h000);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 134) : $urandom_range(0, 16);
        queue_fill(n);
        queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_WRITE, sec));
        last_trk = trk;
        last_sec = sec;
        if ($urandom_range(0, 1)) begin
          queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, sec));
          queue_reads($urandom_range(1, 20));
        end
      end else if (pick < 65) begin
        // sector read, half the time of the last sector written
        if ($urandom_range(0, 1)) begin
          trk = last_trk;
          sec = last_sec;
        end
        if (trk == 0 && $urandom_range(0, 1))
          queue_access(fsc_pkg::ACT_START, 8'h00,
                       command_word(fsc_pkg::OP_RECAL, $urandom_range(0, 255)));
        else
          queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_SEEK, trk));
        queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ, sec));
        queue_reads($urandom_range(1, 24));
      end else if (pick < 75) begin
        // rejected commands; the reads after them show nothing moved
        case ($urandom_range(0, 2))
          0: queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_READ,
                 $urandom_range(0, 1) ? 0 : $urandom_range(SECTORS_PER_TRACK + 1, 255)));
          1: queue_access(fsc_pkg::ACT_START, 8'h00, command_word(fsc_pkg::OP_WRITE,
                 $urandom_range(0, 1) ? 0 : $urandom_range(SECTORS_PER_TRACK + 1, 255)));
          default: queue_access(fsc_pkg::ACT_START, 8'h00,
                                command_word(fsc_pkg::OP_SEEK,
                                             $urandom_range(TRACK_COUNT, 255)));
        endcase
        queue_reads($urandom_range(1, 3));
      end else begin
        // noise: any access with any fields
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          queue_access(fsc_pkg::action_t'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all words sent and every result back, then room for a stray sector copy
    while (access_queue.size() != 0 || in_bus.valid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (BYTES_PER_SECTOR + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Clearing pass plus the slowest traffic ends well before this timeout
  initial begin : watchdog
    #30_000_000;
    $display("TIMEOUT: %0d words unsent, %0d results outstanding",
             access_queue.size(), expected_responses.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
